### hw/rtl/wts_pkg.sv
// Shared types, constants and decode functions for the wavetable track sampler.
// No dependencies; used by every module in hw/rtl.
package wts_pkg;

    localparam int TBL_DEPTH  = 2816;
    localparam int TBL_ADDR_W = 12;
    localparam int REG_ADDR_W = 8;

    // x / 1000 for any 32-bit x: (x * DIV_MAGIC) >> DIV_SHIFT
    localparam logic [31:0] DIV_MAGIC = 32'h1062_4DD3;
    localparam int          DIV_SHIFT = 38;

    localparam logic [31:0] LCG_MUL = 32'd214013;
    localparam logic [31:0] LCG_INC = 32'd2531011;

    localparam logic [7:0] CTRL_START_ONLY = 8'd24;
    localparam logic [7:0] CTRL_REG_SCALE  = 8'd113;

    typedef enum logic [1:0] {
        OP_SAMPLE    = 2'd0,
        OP_TBL_WRITE = 2'd1,
        OP_REG_WRITE = 2'd2,
        OP_SEED      = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        WK_NONE   = 2'd0,
        WK_PLAIN  = 2'd1,
        WK_INTERP = 2'd2,
        WK_NOISE  = 2'd3
    } wave_kind_t;

    typedef struct packed {
        logic                  we;
        logic [TBL_ADDR_W-1:0] waddr;
        logic [7:0]            wdata;
        logic                  re;
        logic [TBL_ADDR_W-1:0] raddr0;
        logic [TBL_ADDR_W-1:0] raddr1;
    } tbl_req_t;

    typedef struct packed {
        logic                  we;
        logic [REG_ADDR_W-1:0] waddr;
        logic [31:0]           wdata;
        logic                  re;
        logic [REG_ADDR_W-1:0] raddr;
    } reg_req_t;

    function automatic wave_kind_t wave_kind(input logic [3:0] func);
        case (func)
            4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd8, 4'd9, 4'd15: wave_kind = WK_PLAIN;
            4'd7, 4'd10: wave_kind = WK_INTERP;
            4'd6:        wave_kind = WK_NOISE;
            default:     wave_kind = WK_NONE;
        endcase
    endfunction

    function automatic logic [TBL_ADDR_W-1:0] wave_base(input logic [3:0] func);
        case (func)
            4'd2:    wave_base = 12'd256;
            4'd3:    wave_base = 12'd768;
            4'd4:    wave_base = 12'd1024;
            4'd5:    wave_base = 12'd1280;
            4'd7:    wave_base = 12'd1536;
            4'd8:    wave_base = 12'd1792;
            4'd9:    wave_base = 12'd2048;
            4'd10:   wave_base = 12'd2304;
            4'd15:   wave_base = 12'd2560;
            default: wave_base = 12'd0;
        endcase
    endfunction

endpackage

### hw/rtl/wts_table_mem.sv
// Wave table storage: one write port, two registered read ports.
// Depends on wts_pkg for the request struct and depth.
module wts_table_mem (
    input  logic              aclk,
    input  wts_pkg::tbl_req_t req,
    output logic [7:0]        rdata0,
    output logic [7:0]        rdata1
);

    logic [7:0] mem [wts_pkg::TBL_DEPTH];
    logic [7:0] rdata0_reg;
    logic [7:0] rdata1_reg;

    always_ff @(posedge aclk) begin
        if (req.we) begin
            mem[req.waddr] <= req.wdata;
        end
        if (req.re) begin
            rdata0_reg <= mem[req.raddr0];
            rdata1_reg <= mem[req.raddr1];
        end
    end

    assign rdata0 = rdata0_reg;
    assign rdata1 = rdata1_reg;

endmodule

### hw/rtl/wts_reg_mem.sv
// Control register file: synchronous memory with per-entry valid bits so
// that unwritten entries read as zero after reset. Depends on wts_pkg.
module wts_reg_mem #(
    parameter int COUNT = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  wts_pkg::reg_req_t req,
    output logic [31:0]       rdata
);

    localparam int IDX_W = (COUNT > 1) ? $clog2(COUNT) : 1;

    logic [31:0]      mem [COUNT];
    logic [COUNT-1:0] valid_reg;
    logic [31:0]      rdata_reg;
    logic             rvalid_reg;

    always_ff @(posedge aclk) begin
        if (req.we) begin
            mem[req.waddr[IDX_W-1:0]] <= req.wdata;
        end
        if (req.re) begin
            rdata_reg <= mem[req.raddr[IDX_W-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg  <= '0;
            rvalid_reg <= 1'b0;
        end else begin
            if (req.we) begin
                valid_reg[req.waddr[IDX_W-1:0]] <= 1'b1;
            end
            if (req.re) begin
                rvalid_reg <= valid_reg[req.raddr[IDX_W-1:0]];
            end
        end
    end

    assign rdata = rvalid_reg ? rdata_reg : 32'd0;

endmodule

### hw/rtl/wavetable_track_sampler.sv
// Top level of the wavetable track sampler: handshake, sequencer and datapath.
// Depends on wts_pkg, wts_table_mem and wts_reg_mem.
//
// Usage: each input word on the s_ channel carries an op. Ops 1 to 3 load a
// table byte, a control register or the noise seed; they take effect on
// acceptance and give no result. Op 0 samples one track and gives one word
// on the m_ channel (sample_value, 24.8 fixed point).
// Path from acceptance to m_valid: an inactive track or control 24 goes
// straight to ST_MUL, control 113 reads the register file (ST_READ,
// ST_WAVE, ST_MUL), and a wave function steps through ST_DIV (reciprocal
// multiply for the /1000), ST_PHASE (phase multiply), ST_READ (table
// read), ST_WAVE (interpolation) and ST_MUL (scale multiply). A sample word
// occupies the sequencer until it leaves ST_MUL; writes leave it idle.
// The result sits in an output register, so a new word is accepted while
// the previous result waits. If the receiver stalls, the next sample holds
// in its last step until the output register frees.
// Reset makes the control registers read zero and sets the noise state to one;
// the wave table is not cleared and must be loaded before it is sampled.
module wavetable_track_sampler #(
    parameter int CTRL_REG_COUNT = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_op,
    input  logic [7:0]         s_track_control,
    input  logic signed [15:0] s_track_start,
    input  logic signed [15:0] s_track_end,
    input  logic [15:0]        s_track_rate,
    input  logic [7:0]         s_track_param,
    input  logic [31:0]        s_time_ms,
    input  logic [11:0]        s_write_addr,
    input  logic signed [31:0] s_write_data,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_sample_value
);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_DIV   = 6'b000010,
        ST_PHASE = 6'b000100,
        ST_READ  = 6'b001000,
        ST_WAVE  = 6'b010000,
        ST_MUL   = 6'b100000
    } state_t;

    state_t                   state_reg, state_next;
    logic                     zero_reg, zero_next;
    logic                     regsel_reg, regsel_next;
    logic                     param_ok_reg, param_ok_next;
    wts_pkg::wave_kind_t      kind_reg, kind_next;
    logic [11:0]              base_reg, base_next;
    logic [7:0]               param_reg, param_next;
    logic [15:0]              rate_reg, rate_next;
    logic [23:0]              time_reg, time_next;
    logic signed [15:0]       start_reg, start_next;
    logic signed [15:0]       end_reg, end_next;
    logic [15:0]              quot_reg, quot_next;
    logic [15:0]              phase_reg, phase_next;
    logic [31:0]              wave_reg, wave_next;
    logic [31:0]              rng_reg, rng_next;
    logic                     m_valid_reg, m_valid_next;
    logic [31:0]              m_data_reg, m_data_next;

    wts_pkg::tbl_req_t tbl_req;
    wts_pkg::reg_req_t reg_req;
    logic [7:0]        tbl_rdata0;
    logic [7:0]        tbl_rdata1;
    logic [31:0]       reg_rdata;

    logic                     accept;
    wts_pkg::op_t             op;
    logic [63:0]              div_prod;
    logic [31:0]              rate_prod;
    logic [7:0]               idx;
    logic [7:0]               idx_inc;
    logic signed [8:0]        diff;
    logic signed [17:0]       interp_prod;
    logic [17:0]              interp_val;
    logic signed [16:0]       delta;
    logic signed [49:0]       scale_prod;
    logic [31:0]              scaled;
    logic [31:0]              start_fx;
    logic                     out_free;

    assign accept  = s_valid && s_ready;
    assign s_ready = (state_reg == ST_IDLE);
    assign op      = wts_pkg::op_t'(s_op);

    // Datapath pieces, one multiplier per step
    assign div_prod  = {32'd0, time_reg, 8'd0} * {32'd0, wts_pkg::DIV_MAGIC};
    assign rate_prod = {16'd0, quot_reg} * {16'd0, rate_reg};
    assign idx       = phase_reg[15:8];
    assign idx_inc   = idx + 8'd1;

    assign diff        = $signed({1'b0, tbl_rdata1}) - $signed({1'b0, tbl_rdata0});
    assign interp_prod = 18'(diff * $signed({1'b0, phase_reg[7:0]}));
    assign interp_val  = 18'(interp_prod) + {2'd0, tbl_rdata0, 8'd0};

    assign delta      = $signed({end_reg[15], end_reg}) - $signed({start_reg[15], start_reg});
    assign scale_prod = $signed({1'b0, wave_reg}) * delta;
    assign scaled     = {{8{scale_prod[31]}}, scale_prod[31:8]};
    assign start_fx   = {{8{start_reg[15]}}, start_reg, 8'd0};
    assign out_free   = !m_valid_reg || m_ready;

    always_comb begin
        state_next    = state_reg;
        zero_next     = zero_reg;
        regsel_next   = regsel_reg;
        param_ok_next = param_ok_reg;
        kind_next     = kind_reg;
        base_next     = base_reg;
        param_next    = param_reg;
        rate_next     = rate_reg;
        time_next     = time_reg;
        start_next    = start_reg;
        end_next      = end_reg;
        quot_next     = quot_reg;
        phase_next    = phase_reg;
        wave_next     = wave_reg;
        rng_next      = rng_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_data_next   = m_data_reg;

        tbl_req.we     = accept && (op == wts_pkg::OP_TBL_WRITE) &&
                         (s_write_addr < 12'(wts_pkg::TBL_DEPTH));
        tbl_req.waddr  = s_write_addr;
        tbl_req.wdata  = s_write_data[7:0];
        tbl_req.re     = 1'b0;
        tbl_req.raddr0 = base_reg + {4'd0, idx};
        tbl_req.raddr1 = base_reg + {4'd0, idx_inc};

        reg_req.we    = accept && (op == wts_pkg::OP_REG_WRITE) &&
                        (32'(s_write_addr) < CTRL_REG_COUNT);
        reg_req.waddr = s_write_addr[7:0];
        reg_req.wdata = s_write_data;
        reg_req.re    = 1'b0;
        reg_req.raddr = param_reg;

        case (state_reg)
            ST_IDLE: begin
                if (accept && (op == wts_pkg::OP_SEED)) begin
                    rng_next = s_write_data;
                end
                if (accept && (op == wts_pkg::OP_SAMPLE)) begin
                    zero_next     = (s_track_control[7:4] == 4'd0);
                    regsel_next   = (s_track_control == wts_pkg::CTRL_REG_SCALE);
                    param_ok_next = (32'(s_track_param) < CTRL_REG_COUNT);
                    kind_next     = wts_pkg::wave_kind(s_track_control[3:0]);
                    base_next     = wts_pkg::wave_base(s_track_control[3:0]);
                    param_next    = s_track_param;
                    rate_next     = s_track_rate;
                    time_next     = s_time_ms[23:0];
                    start_next    = s_track_start;
                    end_next      = s_track_end;
                    wave_next     = 32'd0;
                    if ((s_track_control[7:4] == 4'd0) ||
                        (s_track_control == wts_pkg::CTRL_START_ONLY)) begin
                        state_next = ST_MUL;
                    end else if (s_track_control == wts_pkg::CTRL_REG_SCALE) begin
                        state_next = ST_READ;
                    end else begin
                        state_next = ST_DIV;
                    end
                end
            end
            ST_DIV: begin
                quot_next  = div_prod[wts_pkg::DIV_SHIFT +: 16];
                state_next = ST_PHASE;
            end
            ST_PHASE: begin
                phase_next = {param_reg, 8'd0} + rate_prod[15:0];
                state_next = ST_READ;
            end
            ST_READ: begin
                tbl_req.re = !regsel_reg;
                reg_req.re = regsel_reg;
                if (!regsel_reg && (kind_reg == wts_pkg::WK_NOISE)) begin
                    rng_next = rng_reg * wts_pkg::LCG_MUL + wts_pkg::LCG_INC;
                end
                state_next = ST_WAVE;
            end
            ST_WAVE: begin
                if (regsel_reg) begin
                    wave_next = param_ok_reg ? reg_rdata : 32'd0;
                end else begin
                    case (kind_reg)
                        wts_pkg::WK_PLAIN:  wave_next = {16'd0, tbl_rdata0, 8'd0};
                        wts_pkg::WK_INTERP: wave_next = {16'd0, interp_val[15:0]};
                        wts_pkg::WK_NOISE:  wave_next = {16'd0, rng_reg[27:16], 4'd0};
                        default:            wave_next = 32'd0;
                    endcase
                end
                state_next = ST_MUL;
            end
            ST_MUL: begin
                // hold until the output register is free
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = zero_reg ? 32'd0 : start_fx + scaled;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            rng_reg     <= 32'd1;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            rng_reg     <= rng_next;
        end
    end

    always_ff @(posedge aclk) begin
        zero_reg     <= zero_next;
        regsel_reg   <= regsel_next;
        param_ok_reg <= param_ok_next;
        kind_reg     <= kind_next;
        base_reg     <= base_next;
        param_reg    <= param_next;
        rate_reg     <= rate_next;
        time_reg     <= time_next;
        start_reg    <= start_next;
        end_reg      <= end_next;
        quot_reg     <= quot_next;
        phase_reg    <= phase_next;
        wave_reg     <= wave_next;
        m_data_reg   <= m_data_next;
    end

    wts_table_mem u_table (
        .aclk   (aclk),
        .req    (tbl_req),
        .rdata0 (tbl_rdata0),
        .rdata1 (tbl_rdata1)
    );

    wts_reg_mem #(
        .COUNT (CTRL_REG_COUNT)
    ) u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (reg_req),
        .rdata   (reg_rdata)
    );

    assign m_valid        = m_valid_reg;
    assign m_sample_value = $signed(m_data_reg);

    // A write word never produces a result word
    a_write_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (s_op != wts_pkg::OP_SAMPLE) && !m_valid) |=> !m_valid)
        else $error("result appeared after a write word");

    // A finished sample waits while the output register is still held
    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_MUL) && m_valid && !m_ready) |=>
        ((state_reg == ST_MUL) && m_valid))
        else $error("sample left its last step while output stalled");

    // Table reads stay inside the table
    a_tbl_addr: assert property (@(posedge aclk) disable iff (!aresetn)
        tbl_req.re |-> ((tbl_req.raddr0 < 12'(wts_pkg::TBL_DEPTH)) &&
                        (tbl_req.raddr1 < 12'(wts_pkg::TBL_DEPTH))))
        else $error("table read beyond depth");

    // Table and register file are never read in the same cycle
    a_one_read: assert property (@(posedge aclk) disable iff (!aresetn)
        !(tbl_req.re && reg_req.re))
        else $error("table and register file read together");

endmodule

### tb/sv/wts_tb_pkg.sv
`timescale 1ns / 100ps
// Track word type and scoreboard for the wavetable track sampler bench.
// Depends on wts_pkg for the op codes and the control codes of the block.
package wts_tb_pkg;

    import wts_pkg::*;

    localparam int WAVE_BYTES = 2816;
    localparam int CTRL_REGS  = 16;
    localparam int SEG_BYTES  = 256;

    localparam bit [31:0] NOISE_MUL  = 32'd214013;
    localparam bit [31:0] NOISE_INC  = 32'd2531011;
    localparam bit [31:0] MS_DIVISOR = 32'd1000;

    // Low nibble of the control byte; SEGn names the 256-byte segment read.
    typedef enum bit [3:0] {
        WF_OFF   = 4'd0,
        WF_SEG0  = 4'd1,
        WF_SEG1  = 4'd2,
        WF_SEG3  = 4'd3,
        WF_SEG4  = 4'd4,
        WF_SEG5  = 4'd5,
        WF_NOISE = 4'd6,
        WF_LERP6 = 4'd7,
        WF_SEG7  = 4'd8,
        WF_SEG8  = 4'd9,
        WF_LERP9 = 4'd10,
        WF_SEG10 = 4'd15
    } wave_fn_t;

    typedef struct {
        op_t       op;
        bit [7:0]  ctrl;
        bit [15:0] start_val;
        bit [15:0] end_val;
        bit [15:0] rate;
        bit [7:0]  param;
        bit [31:0] time_ms;
        bit [11:0] waddr;
        bit [31:0] wdata;
    } track_word_t;

    typedef struct {
        bit [31:0] value;
        bit [7:0]  ctrl;
    } sample_expect_t;

    class track_scoreboard;
        bit [7:0]       wave_mem [WAVE_BYTES];
        bit [31:0]      ctrl_reg [CTRL_REGS];
        bit [31:0]      noise_state;
        sample_expect_t expected_samples [$];
        int             errors;

        function new();
            noise_state = 32'd1;
            errors      = 0;
        endfunction

        // Low 32 bits of the product, shifted right arithmetically by 8
        function bit [31:0] scale_sar8(bit [31:0] a, bit [31:0] b);
            bit signed [31:0] prod;
            prod = a * b;
            return prod >>> 8;
        endfunction

        function bit [31:0] wave_level(bit [3:0] fn, bit [15:0] phase);
            bit [7:0]  idx;
            bit [7:0]  nidx;
            bit [7:0]  frac;
            bit [31:0] v0;
            bit [31:0] v1;
            int        seg;
            idx  = phase[15:8];
            frac = phase[7:0];
            nidx = idx + 8'd1;
            if (fn == WF_NOISE) begin
                noise_state = noise_state * NOISE_MUL + NOISE_INC;
                return {16'd0, noise_state[27:16], 4'd0};
            end
            case (fn)
                WF_SEG0:  seg = 0;
                WF_SEG1:  seg = 1;
                WF_SEG3:  seg = 3;
                WF_SEG4:  seg = 4;
                WF_SEG5:  seg = 5;
                WF_LERP6: seg = 6;
                WF_SEG7:  seg = 7;
                WF_SEG8:  seg = 8;
                WF_LERP9: seg = 9;
                WF_SEG10: seg = 10;
                default:  seg = -1;
            endcase
            if (seg < 0)
                return 32'd0;
            v0 = wave_mem[seg * SEG_BYTES + idx];
            if (fn != WF_LERP6 && fn != WF_LERP9)
                return v0 << 8;
            // neighbour wraps within the segment
            v1 = wave_mem[seg * SEG_BYTES + nidx];
            return (v1 - v0) * frac + (v0 << 8);
        endfunction

        function bit [31:0] predict_sample(track_word_t w);
            bit [31:0] s_fix;
            bit [31:0] span;
            bit [31:0] reg_val;
            bit [31:0] scaled_t;
            bit [31:0] phase_full;
            s_fix = {{16{w.start_val[15]}}, w.start_val} << 8;
            span  = {{16{w.end_val[15]}}, w.end_val} - {{16{w.start_val[15]}}, w.start_val};
            if (w.ctrl[7:4] == 4'd0)
                return 32'd0;
            if (w.ctrl == CTRL_START_ONLY)
                return s_fix;
            if (w.ctrl == CTRL_REG_SCALE) begin
                reg_val = (w.param < CTRL_REGS) ? ctrl_reg[w.param] : 32'd0;
                return s_fix + scale_sar8(reg_val, span);
            end
            scaled_t   = w.time_ms << 8;
            phase_full = {16'd0, w.param, 8'd0} + (scaled_t / MS_DIVISOR) * {16'd0, w.rate};
            return s_fix + scale_sar8(wave_level(w.ctrl[3:0], phase_full[15:0]), span);
        endfunction

        function void note_word(track_word_t w);
            sample_expect_t e;
            case (w.op)
                OP_SAMPLE: begin
                    e.value = predict_sample(w);
                    e.ctrl  = w.ctrl;
                    expected_samples.push_back(e);
                end
                OP_TBL_WRITE: begin
                    if (w.waddr < WAVE_BYTES)
                        wave_mem[w.waddr] = w.wdata[7:0];
                end
                OP_REG_WRITE: begin
                    if (w.waddr < CTRL_REGS)
                        ctrl_reg[w.waddr] = w.wdata;
                end
                default: noise_state = w.wdata;
            endcase
        endfunction

        task report(string what);
            errors++;
            $display("MISMATCH %0t: %s", $time, what);
        endtask

        task check_result(logic [31:0] got);
            sample_expect_t e;
            if (expected_samples.size() == 0) begin
                report($sformatf("sample_value %h with no sample pending", got));
                return;
            end
            e = expected_samples.pop_front();
            if (got !== e.value)
                report($sformatf("control %h: sample_value %h, want %h", e.ctrl, got, e.value));
        endtask
    endclass

endpackage

### tb/sv/tb_top.sv
`timescale 1ns / 100ps
// Top-level bench for wavetable_track_sampler: directed and random words,
// random idling on both channels. Depends on wts_pkg and wts_tb_pkg.
module tb_top;

    import wts_pkg::*;
    import wts_tb_pkg::*;

    localparam int IDLE_PCT       = 21;
    localparam int RANDOM_WORDS   = 1100;
    localparam int RX_HOLD_CYCLES = 300;
    localparam int STALL_LIMIT    = 5000;
    localparam int DRAIN_CYCLES   = 20;

    // Loaded bytes of each segment: LOAD_SPAN bytes from LOAD_FIRST, wrapping
    localparam int LOAD_FIRST = 224;
    localparam int LOAD_SPAN  = 80;

    localparam wave_fn_t PROBE_FNS [12] = '{WF_OFF, WF_SEG0, WF_SEG1, WF_SEG3, WF_SEG4,
        WF_SEG5, WF_LERP6, WF_SEG7, WF_SEG8, WF_LERP9, WF_SEG10, WF_NOISE};

    logic               aclk            = 1'b0;
    logic               aresetn         = 1'b0;
    logic               s_valid         = 1'b0;
    logic               s_ready;
    op_t                s_op            = OP_SAMPLE;
    logic [7:0]         s_track_control = '0;
    logic signed [15:0] s_track_start   = '0;
    logic signed [15:0] s_track_end     = '0;
    logic [15:0]        s_track_rate    = '0;
    logic [7:0]         s_track_param   = '0;
    logic [31:0]        s_time_ms       = '0;
    logic [11:0]        s_write_addr    = '0;
    logic signed [31:0] s_write_data    = '0;
    logic               m_valid;
    logic               m_ready         = 1'b0;
    logic signed [31:0] m_sample_value;

    track_scoreboard sb;
    int              tx_idle_pct = IDLE_PCT;
    int              rx_idle_pct = IDLE_PCT;
    bit              rx_hold_req = 1'b0;

    wavetable_track_sampler #(
        .CTRL_REG_COUNT(CTRL_REGS)
    ) i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_op           (s_op),
        .s_track_control(s_track_control),
        .s_track_start  (s_track_start),
        .s_track_end    (s_track_end),
        .s_track_rate   (s_track_rate),
        .s_track_param  (s_track_param),
        .s_time_ms      (s_time_ms),
        .s_write_addr   (s_write_addr),
        .s_write_data   (s_write_data),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_sample_value (m_sample_value)
    );

    always #10 aclk = ~aclk;

    // Called in the step of a rising edge; returns in the step of acceptance.
    task automatic send_word(track_word_t w);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_op            <= w.op;
        s_track_control <= w.ctrl;
        s_track_start   <= w.start_val;
        s_track_end     <= w.end_val;
        s_track_rate    <= w.rate;
        s_track_param   <= w.param;
        s_time_ms       <= w.time_ms;
        s_write_addr    <= w.waddr;
        s_write_data    <= w.wdata;
        do @(posedge aclk); while (!s_ready);
        sb.note_word(w);
    endtask

    task automatic send_sample(bit [7:0] ctrl, bit [15:0] start_val, bit [15:0] end_val,
                               bit [15:0] rate, bit [7:0] param, bit [31:0] time_ms);
        track_word_t w;
        w.op        = OP_SAMPLE;
        w.ctrl      = ctrl;
        w.start_val = start_val;
        w.end_val   = end_val;
        w.rate      = rate;
        w.param     = param;
        w.time_ms   = time_ms;
        w.waddr     = 12'($urandom());
        w.wdata     = $urandom();
        send_word(w);
    endtask

    task automatic send_write(op_t op, bit [11:0] waddr, bit [31:0] wdata);
        track_word_t w;
        w.op        = op;
        w.ctrl      = 8'($urandom());
        w.start_val = 16'($urandom());
        w.end_val   = 16'($urandom());
        w.rate      = 16'($urandom());
        w.param     = 8'($urandom());
        w.time_ms   = $urandom();
        w.waddr     = waddr;
        w.wdata     = wdata;
        send_word(w);
    endtask

    // Drop valid and hold until every pending sample has come back
    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (sb.expected_samples.size() != 0);
    endtask

    function automatic bit [15:0] edge_value16();
        case ($urandom_range(19))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'h0000;
            3:       return 16'hFFFF;
            default: return 16'($urandom());
        endcase
    endfunction

    // True when the control byte makes the sample depend on table bytes
    function automatic bit reads_table(bit [7:0] ctrl);
        if (ctrl[7:4] == 4'd0 || ctrl == CTRL_START_ONLY || ctrl == CTRL_REG_SCALE)
            return 1'b0;
        case (ctrl[3:0])
            WF_SEG0, WF_SEG1, WF_SEG3, WF_SEG4, WF_SEG5, WF_LERP6,
            WF_SEG7, WF_SEG8, WF_LERP9, WF_SEG10: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    // Pick the phase offset that lands the segment index on loaded bytes,
    // neighbour included
    function automatic bit [7:0] fit_param(bit [15:0] rate, bit [31:0] time_ms);
        bit [31:0] ticks;
        bit [31:0] advance;
        bit [7:0]  target;
        ticks   = (time_ms << 8) / MS_DIVISOR;
        advance = ticks * {16'd0, rate};
        target  = 8'(LOAD_FIRST + $urandom_range(LOAD_SPAN - 2));
        return target - advance[15:8];
    endfunction

    initial begin
        int unsigned pick;
        bit [7:0]    ctrl;
        bit [7:0]    param;
        bit [15:0]   rate;
        bit [11:0]   waddr;
        bit [31:0]   tm;
        sb = new();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // Cases that use no table byte
        send_sample(8'h0F, 16'h8000, 16'h7FFF, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF);
        send_sample(CTRL_START_ONLY, 16'h7FFF, 16'h8000, 16'h0000, 8'h00, 32'h0);
        send_sample(CTRL_START_ONLY, 16'h8000, 16'h7FFF, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF);
        send_write(OP_REG_WRITE, 12'd0, 32'h7FFF_FFFF);
        send_write(OP_REG_WRITE, 12'(CTRL_REGS - 1), 32'h8000_0000);
        send_write(OP_REG_WRITE, 12'hFFF, 32'hFFFF_FFFF);
        send_sample(CTRL_REG_SCALE, 16'h8000, 16'h7FFF, 16'h0, 8'd0, 32'h0);
        send_sample(CTRL_REG_SCALE, 16'h7FFF, 16'h8000, 16'h0, 8'(CTRL_REGS - 1), 32'h0);
        // ordinal beyond the register file scales by zero
        send_sample(CTRL_REG_SCALE, 16'h1234, 16'h8000, 16'h0, 8'hFF, 32'h0);
        send_write(OP_SEED, 12'h0, 32'hFFFF_FFFF);
        send_sample({4'hF, WF_NOISE}, 16'h8000, 16'h7FFF, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF);
        send_write(OP_TBL_WRITE, 12'hFFF, 32'hFFFF_FFFF);
        send_write(OP_TBL_WRITE, 12'(WAVE_BYTES), 32'h0000_00A5);
        wait_drained();

        // Load the bytes around the end of every segment before any wave read
        for (int seg = 0; seg < WAVE_BYTES / SEG_BYTES; seg++)
            for (int k = 0; k < LOAD_SPAN; k++)
                send_write(OP_TBL_WRITE,
                           12'(seg * SEG_BYTES + ((LOAD_FIRST + k) % SEG_BYTES)), $urandom());

        send_sample({4'h1, WF_SEG0}, 16'h8000, 16'h7FFF, 16'hFFFF,
                    fit_param(16'hFFFF, 32'hFFFF_FFFF), 32'hFFFF_FFFF);
        // phase 0xFF80: last byte of each segment, interpolation wraps to byte 0
        foreach (PROBE_FNS[i])
            send_sample({4'hF, PROBE_FNS[i]}, 16'h8000, 16'h7FFF, 16'h0080, 8'hFF, 32'd4);

        for (int n = 0; n < RANDOM_WORDS; n++) begin
            if (n == 300)
                wait_drained();
            if (n == 400) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            if (n == 650) begin
                tx_idle_pct = IDLE_PCT;
                rx_idle_pct = IDLE_PCT;
            end
            if (n == 800)
                rx_hold_req = 1'b1;
            pick = $urandom_range(99);
            if (pick < 65) begin
                case ($urandom_range(19))
                    0, 1:    ctrl = {4'h0, 4'($urandom())};
                    2, 3:    ctrl = CTRL_START_ONLY;
                    4, 5, 6: ctrl = CTRL_REG_SCALE;
                    default: ctrl = {4'($urandom_range(15, 1)), 4'($urandom())};
                endcase
                rate = ($urandom_range(3) == 0) ? 16'($urandom_range(3)) : 16'($urandom());
                tm   = $urandom();
                if (ctrl == CTRL_REG_SCALE && $urandom_range(9) != 0)
                    param = 8'($urandom_range(CTRL_REGS - 1));
                else if (reads_table(ctrl))
                    param = fit_param(rate, tm);
                else
                    param = 8'($urandom());
                send_sample(ctrl, edge_value16(), edge_value16(), rate, param, tm);
            end else if (pick < 77) begin
                waddr = ($urandom_range(9) == 0) ? 12'($urandom_range(4095, WAVE_BYTES))
                                                 : 12'($urandom_range(WAVE_BYTES - 1));
                send_write(OP_TBL_WRITE, waddr, $urandom());
            end else if (pick < 90) begin
                waddr = ($urandom_range(4) == 0) ? 12'($urandom())
                                                 : 12'($urandom_range(CTRL_REGS - 1));
                send_write(OP_REG_WRITE, waddr, $urandom());
            end else begin
                send_write(OP_SEED, 12'($urandom()), $urandom());
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.errors == 0 && sb.expected_samples.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // Result side: random stalls, plus one long hold-off on request
    initial begin
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge aclk);
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                hold_left   = RX_HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                m_ready <= 1'b0;
                hold_left--;
            end else begin
                m_ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_result(m_sample_value);
    end

    // Count cycles with no word moving on either channel; fail at STALL_LIMIT
    initial begin
        int quiet;
        quiet = 0;
        forever begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= STALL_LIMIT) begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

endmodule

### sim.f
hw/rtl/wts_pkg.sv
hw/rtl/wts_table_mem.sv
hw/rtl/wts_reg_mem.sv
hw/rtl/wavetable_track_sampler.sv
tb/sv/wts_tb_pkg.sv
tb/sv/tb_top.sv
